[rtl/core/rtj_pkg.sv]
package rtj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AGW = 19;
  localparam int PTW = 20;
  localparam int TW  = FRAC_BITS + 2;
  localparam int VW  = 26;
  localparam int PW  = 2 * VW;
  localparam int AW  = 56;
  localparam int CW  = 34;
  localparam int CQ_SHIFT = 30 - FRAC_BITS;

  typedef logic signed [AGW-1:0] ang_t;
  typedef logic signed [PTW-1:0] pt_t;
  typedef logic signed [TW-1:0]  trig_val_t;
  typedef logic signed [VW-1:0]  vec_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [AW-1:0]  acc_t;
  typedef logic signed [CW-1:0]  cq_t;

  typedef struct packed {
    trig_val_t sin_r;
    trig_val_t cos_r;
    trig_val_t sin_p;
    trig_val_t cos_p;
    trig_val_t sin_y;
    trig_val_t cos_y;
  } trig_t;

  typedef struct packed {
    pt_t  rx;
    pt_t  ry;
    pt_t  rz;
    pt_t  sx;
    pt_t  sy;
    pt_t  sz;
    logic last;
  } pair_t;

  // rotated point, roll/pitch gradient terms and the reference point
  typedef struct packed {
    vec_t q0;
    vec_t q1;
    vec_t q2;
    vec_t gr0;
    vec_t gr1;
    vec_t gr2;
    vec_t u;
    vec_t gp2;
    pt_t  rx;
    pt_t  ry;
    pt_t  rz;
    logic last;
  } rot_t;

  localparam cq_t PI_Q30      = 34'sd3373259426;
  localparam cq_t HALF_PI_Q30 = 34'sd1686629713;
  localparam cq_t TWO_PI_Q30  = 34'sd6746518852;
  localparam cq_t GAIN_Q30    = 34'sd652032875;
  localparam cq_t CQ_HALF     = cq_t'(1) <<< (CQ_SHIFT - 1);
  localparam cq_t CQ_ONE      = cq_t'(1) <<< FRAC_BITS;

  localparam prod_t PROD_HALF = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t  ACC_HALF  = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t  S32_MAX   = acc_t'(2147483647);
  localparam acc_t  S32_MIN   = -S32_MAX - acc_t'(1);
  localparam acc_t  U32_MAX   = acc_t'(33'h0_FFFF_FFFF);

  localparam logic [2:0] CFG_ROLL    = 3'd0;
  localparam logic [2:0] CFG_PITCH   = 3'd1;
  localparam logic [2:0] CFG_YAW     = 3'd2;
  localparam logic [2:0] CFG_SHIFT_X = 3'd3;
  localparam logic [2:0] CFG_SHIFT_Y = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Z = 3'd5;
  localparam logic [2:0] CFG_COUNT   = 3'd6;

  localparam logic [1:0] ANG_ROLL  = 2'd0;
  localparam logic [1:0] ANG_PITCH = 2'd1;
  localparam logic [1:0] ANG_YAW   = 2'd2;

  function automatic cq_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    atan_q30 = 34'sd843314857;
      5'd1:    atan_q30 = 34'sd497837829;
      5'd2:    atan_q30 = 34'sd263043837;
      5'd3:    atan_q30 = 34'sd133525159;
      5'd4:    atan_q30 = 34'sd67021687;
      5'd5:    atan_q30 = 34'sd33543516;
      5'd6:    atan_q30 = 34'sd16775851;
      5'd7:    atan_q30 = 34'sd8388437;
      5'd8:    atan_q30 = 34'sd4194283;
      5'd9:    atan_q30 = 34'sd2097149;
      5'd10:   atan_q30 = 34'sd1048576;
      5'd11:   atan_q30 = 34'sd524288;
      5'd12:   atan_q30 = 34'sd262144;
      5'd13:   atan_q30 = 34'sd131072;
      5'd14:   atan_q30 = 34'sd65536;
      5'd15:   atan_q30 = 34'sd32768;
      5'd16:   atan_q30 = 34'sd16384;
      5'd17:   atan_q30 = 34'sd8192;
      5'd18:   atan_q30 = 34'sd4096;
      5'd19:   atan_q30 = 34'sd2048;
      5'd20:   atan_q30 = 34'sd1024;
      5'd21:   atan_q30 = 34'sd512;
      5'd22:   atan_q30 = 34'sd256;
      5'd23:   atan_q30 = 34'sd128;
      default: atan_q30 = '0;
    endcase
  endfunction

  function automatic vec_t tv(input trig_val_t t);
    return vec_t'(t);
  endfunction

  function automatic vec_t pv(input pt_t p);
    return vec_t'(p);
  endfunction

  // product rounded half up back to the fixed point grid
  function automatic vec_t mulq(input vec_t a, input vec_t b);
    prod_t p;
    p = prod_t'(a) * prod_t'(b) + PROD_HALF;
    return p[FRAC_BITS+VW-1:FRAC_BITS];
  endfunction

  function automatic prod_t mulw(input vec_t a, input vec_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic acc_t rnd_q(input acc_t v);
    return (v + ACC_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] sat_s32(input acc_t v);
    acc_t t;
    t = v;
    if (t > S32_MAX) t = S32_MAX;
    else if (t < S32_MIN) t = S32_MIN;
    return t[31:0];
  endfunction

  function automatic logic [31:0] sat_u32(input acc_t v);
    acc_t t;
    t = v;
    if (t > U32_MAX) t = U32_MAX;
    return t[31:0];
  endfunction

endpackage

[rtl/core/rtj_cordic.sv]
module rtj_cordic
  import rtj_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  restart,
  input  ang_t  roll,
  input  ang_t  pitch,
  input  ang_t  yaw,
  output trig_t trig,
  output logic  trig_valid
);

  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ITER  = 4'b0010,
    ST_STORE = 4'b0100,
    ST_DONE  = 4'b1000
  } cst_t;

  cst_t          state_r;
  logic [1:0]    idx_r;
  logic [SW-1:0] step_r;
  cq_t           x_r, y_r, z_r;
  logic          neg_r;
  trig_t         trig_r;
  logic          valid_r;

  ang_t      ang;
  cq_t       z0, z1, z2;
  logic      neg0;
  cq_t       dx, dy, at;
  trig_val_t sin_v, cos_v;

  function automatic trig_val_t finish(input cq_t v, input logic ng);
    cq_t t;
    t = (v + CQ_HALF) >>> CQ_SHIFT;
    if (ng) t = -t;
    if (t > CQ_ONE) t = CQ_ONE;
    else if (t < -CQ_ONE) t = -CQ_ONE;
    return t[TW-1:0];
  endfunction

  always_comb begin
    case (idx_r)
      ANG_ROLL:  ang = roll;
      ANG_PITCH: ang = pitch;
      default:   ang = yaw;
    endcase
    z0 = cq_t'(ang) <<< CQ_SHIFT;
    // bring into -pi..pi, then fold to the right half plane
    if (z0 > PI_Q30) z1 = z0 - TWO_PI_Q30;
    else if (z0 < -PI_Q30) z1 = z0 + TWO_PI_Q30;
    else z1 = z0;
    neg0 = 1'b0;
    z2 = z1;
    if (z1 > HALF_PI_Q30) begin
      z2 = z1 - PI_Q30;
      neg0 = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      z2 = z1 + PI_Q30;
      neg0 = 1'b1;
    end
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = atan_q30(5'(step_r));
    sin_v = finish(y_r, neg_r);
    cos_v = finish(x_r, neg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= ANG_ROLL;
      step_r  <= '0;
      valid_r <= 1'b0;
      trig_r  <= '0;
    end else if (restart) begin
      state_r <= ST_LOAD;
      idx_r   <= ANG_ROLL;
      valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          x_r     <= GAIN_Q30;
          y_r     <= '0;
          z_r     <= z2;
          neg_r   <= neg0;
          step_r  <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) state_r <= ST_STORE;
        end
        ST_STORE: begin
          case (idx_r)
            ANG_ROLL: begin
              trig_r.sin_r <= sin_v;
              trig_r.cos_r <= cos_v;
            end
            ANG_PITCH: begin
              trig_r.sin_p <= sin_v;
              trig_r.cos_p <= cos_v;
            end
            default: begin
              trig_r.sin_y <= sin_v;
              trig_r.cos_y <= cos_v;
            end
          endcase
          if (idx_r == ANG_YAW) begin
            state_r <= ST_DONE;
            valid_r <= 1'b1;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_LOAD;
          end
        end
        ST_DONE: state_r <= ST_DONE;
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign trig       = trig_r;
  assign trig_valid = valid_r;

endmodule

[rtl/core/rtj_rotate.sv]
module rtj_rotate
  import rtj_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_v,
  input  pair_t pair,
  input  trig_t trig,
  output logic  rot_v,
  output rot_t  rot
);

  vec_t sr, cr, sp, cp, sy, cy;
  assign sr = tv(trig.sin_r);
  assign cr = tv(trig.cos_r);
  assign sp = tv(trig.sin_p);
  assign cp = tv(trig.cos_p);
  assign sy = tv(trig.sin_y);
  assign cy = tv(trig.cos_y);

  // stage 1: products of angle terms and of angles with the sensor point
  logic  v1_r;
  pair_t p1_r;
  vec_t  a1_r, b1_r, c1_r, d1_r, r21_1_r, r22_1_r, m00_1_r, m10_1_r;
  vec_t  srsy1_r, crsz1_r, spsx1_r, cpsx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= pair;
      a1_r    <= mulq(sy, cr);
      b1_r    <= mulq(sr, cy);
      c1_r    <= mulq(sr, sy);
      d1_r    <= mulq(cr, cy);
      r21_1_r <= mulq(sr, cp);
      r22_1_r <= mulq(cr, cp);
      m00_1_r <= mulq(cy, cp);
      m10_1_r <= mulq(sy, cp);
      srsy1_r <= mulq(sr, pv(pair.sy));
      crsz1_r <= mulq(cr, pv(pair.sz));
      spsx1_r <= mulq(sp, pv(pair.sx));
      cpsx1_r <= mulq(cp, pv(pair.sx));
    end
  end

  // stage 2: remaining rotation matrix entries
  logic  v2_r;
  pair_t p2_r;
  vec_t  r01_r, r02_r, r11_r, r12_r, r21_r, r22_r, m00_r, m10_r;
  vec_t  w_r, spsx2_r, cpsx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r    <= p1_r;
      r01_r   <= mulq(b1_r, sp) - a1_r;
      r02_r   <= mulq(d1_r, sp) + c1_r;
      r11_r   <= mulq(c1_r, sp) + d1_r;
      r12_r   <= mulq(a1_r, sp) - b1_r;
      r21_r   <= r21_1_r;
      r22_r   <= r22_1_r;
      m00_r   <= m00_1_r;
      m10_r   <= m10_1_r;
      w_r     <= srsy1_r + crsz1_r;
      spsx2_r <= spsx1_r;
      cpsx2_r <= cpsx1_r;
    end
  end

  // stage 3: rotated point and gradient terms
  logic v3_r;
  rot_t rot_r;
  vec_t sx, sy_p, sz;
  assign sx   = pv(p2_r.sx);
  assign sy_p = pv(p2_r.sy);
  assign sz   = pv(p2_r.sz);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r.q0   <= mulq(m00_r, sx) + mulq(r01_r, sy_p) + mulq(r02_r, sz);
      rot_r.q1   <= mulq(m10_r, sx) + mulq(r11_r, sy_p) + mulq(r12_r, sz);
      rot_r.q2   <= mulq(r21_r, sy_p) + mulq(r22_r, sz) - spsx2_r;
      rot_r.gr0  <= mulq(r02_r, sy_p) - mulq(r01_r, sz);
      rot_r.gr1  <= mulq(r12_r, sy_p) - mulq(r11_r, sz);
      rot_r.gr2  <= mulq(r22_r, sy_p) - mulq(r21_r, sz);
      rot_r.u    <= mulq(cp, w_r) - spsx2_r;
      rot_r.gp2  <= -cpsx2_r - mulq(sp, w_r);
      rot_r.rx   <= p2_r.rx;
      rot_r.ry   <= p2_r.ry;
      rot_r.rz   <= p2_r.rz;
      rot_r.last <= p2_r.last;
    end
  end

  assign rot_v = v3_r;
  assign rot   = rot_r;

endmodule

[rtl/core/rtj_residual.sv]
module rtj_residual
  import rtj_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         rot_v,
  input  rot_t         rot,
  input  trig_t        trig,
  input  vec_t         tx,
  input  vec_t         ty,
  input  vec_t         tz,
  output logic         adv,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [223:0] out_tdata,
  output logic         out_tlast
);

  logic out_valid_r;
  assign adv = !out_valid_r || out_tready;

  // stage 4: residual and pitch gradient
  logic v4_r, last4_r;
  vec_t e0_r, e1_r, e2_r, q0_4_r, q1_4_r, gr0_r, gr1_r, gr2_r, gp0_r, gp1_r, gp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= rot_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_r    <= rot.q0 + tx - pv(rot.rx);
      e1_r    <= rot.q1 + ty - pv(rot.ry);
      e2_r    <= rot.q2 + tz - pv(rot.rz);
      q0_4_r  <= rot.q0;
      q1_4_r  <= rot.q1;
      gr0_r   <= rot.gr0;
      gr1_r   <= rot.gr1;
      gr2_r   <= rot.gr2;
      gp0_r   <= mulq(tv(trig.cos_y), rot.u);
      gp1_r   <= mulq(tv(trig.sin_y), rot.u);
      gp2_r   <= rot.gp2;
      last4_r <= rot.last;
    end
  end

  // stage 5: full-width products
  logic  v5_r, last5_r;
  prod_t ee0_r, ee1_r, ee2_r, er0_r, er1_r, er2_r, ep0_r, ep1_r, ep2_r, yq0_r, yq1_r;
  vec_t  e0_5_r, e1_5_r, e2_5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ee0_r   <= mulw(e0_r, e0_r);
      ee1_r   <= mulw(e1_r, e1_r);
      ee2_r   <= mulw(e2_r, e2_r);
      er0_r   <= mulw(e0_r, gr0_r);
      er1_r   <= mulw(e1_r, gr1_r);
      er2_r   <= mulw(e2_r, gr2_r);
      ep0_r   <= mulw(e0_r, gp0_r);
      ep1_r   <= mulw(e1_r, gp1_r);
      ep2_r   <= mulw(e2_r, gp2_r);
      yq0_r   <= mulw(e1_r, q0_4_r);
      yq1_r   <= mulw(e0_r, q1_4_r);
      e0_5_r  <= e0_r;
      e1_5_r  <= e1_r;
      e2_5_r  <= e2_r;
      last5_r <= last4_r;
    end
  end

  // stage 6: sums, rounding and saturation into the output register
  acc_t sq_sum, roll_sum, pitch_sum, yaw_sum;
  acc_t sx2, sy2, sz2;
  always_comb begin
    sq_sum    = acc_t'(ee0_r) + acc_t'(ee1_r) + acc_t'(ee2_r);
    roll_sum  = (acc_t'(er0_r) + acc_t'(er1_r) + acc_t'(er2_r)) <<< 1;
    pitch_sum = (acc_t'(ep0_r) + acc_t'(ep1_r) + acc_t'(ep2_r)) <<< 1;
    yaw_sum   = (acc_t'(yq0_r) - acc_t'(yq1_r)) <<< 1;
    sx2       = acc_t'(e0_5_r) <<< 1;
    sy2       = acc_t'(e1_5_r) <<< 1;
    sz2       = acc_t'(e2_5_r) <<< 1;
  end

  logic [223:0] data_r;
  logic         last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= {sat_s32(sz2), sat_s32(sy2), sat_s32(sx2),
                 sat_s32(rnd_q(yaw_sum)), sat_s32(rnd_q(pitch_sum)),
                 sat_s32(rnd_q(roll_sum)), sat_u32(rnd_q(sq_sum))};
      last_r <= last5_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

[rtl/core/rigid_transform_residual_jacobian.sv]
// Squared point-pair error and its gradient over a roll/pitch/yaw + translation pose.
// Takes one sensor/reference pair per clock while in_tready is high, through a
// six-stage pipeline that stalls as a whole when the output is held off.
// Sines and cosines of the three angles come from one shared iterative CORDIC: after
// reset and after every register write to an index below CFG_COUNT it recomputes them
// one angle at a time with in_tready low, then the cached values serve every pair.
// Register writes are meant for when no pair is in flight.
module rigid_transform_residual_jacobian
  import rtj_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ref_x, ref_y, ref_z, sensor_x, sensor_y, sensor_z (20 bits each)
  input  logic [119:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sq_error, d_roll, d_pitch, d_yaw, d_shift_x, d_shift_y, d_shift_z (32 bits each)
  output logic [223:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [18:0]  cfg_data
);

  ang_t        roll_r, pitch_r, yaw_r, shx_r, shz_r;
  logic [17:0] shy_r;
  logic        cfg_wr, restart;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index < CFG_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      shx_r   <= '0;
      shy_r   <= 18'(1) << (FRAC_BITS - 1);
      shz_r   <= ang_t'(1) <<< FRAC_BITS;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROLL:    roll_r  <= cfg_data;
        CFG_PITCH:   pitch_r <= cfg_data;
        CFG_YAW:     yaw_r   <= cfg_data;
        CFG_SHIFT_X: shx_r   <= cfg_data;
        CFG_SHIFT_Y: shy_r   <= cfg_data[17:0];
        CFG_SHIFT_Z: shz_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  trig_t trig;
  logic  trig_valid;

  rtj_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .roll       (roll_r),
    .pitch      (pitch_r),
    .yaw        (yaw_r),
    .trig       (trig),
    .trig_valid (trig_valid)
  );

  logic  adv;
  pair_t pair;
  logic  rot_v;
  rot_t  rot;

  assign in_tready = adv && trig_valid;
  assign pair.rx   = in_tdata[19:0];
  assign pair.ry   = in_tdata[39:20];
  assign pair.rz   = in_tdata[59:40];
  assign pair.sx   = in_tdata[79:60];
  assign pair.sy   = in_tdata[99:80];
  assign pair.sz   = in_tdata[119:100];
  assign pair.last = in_tlast;

  rtj_rotate u_rotate (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (in_tvalid && in_tready),
    .pair  (pair),
    .trig  (trig),
    .rot_v (rot_v),
    .rot   (rot)
  );

  rtj_residual u_residual (
    .clk        (clk),
    .rst_n      (rst_n),
    .rot_v      (rot_v),
    .rot        (rot),
    .trig       (trig),
    .tx         (vec_t'(shx_r)),
    .ty         (vec_t'({1'b0, shy_r})),
    .tz         (vec_t'(shz_r)),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/core/rtj_checker.sv]
module rtj_checker
  import rtj_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [2:0]   cfg_index,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata
);

  // trig values are recomputed after reset before any pair is taken
  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // a register write to an index below CFG_COUNT invalidates the cached trig values
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index < CFG_COUNT)) |=> !in_tready)
    else $error("input ready right after register write");

  // the translation gradients are twice the residual, so always even
  a_shift_grad_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[128] && !out_tdata[160] && !out_tdata[192]))
    else $error("odd translation gradient");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result transaction dropped or changed while stalled");

endmodule

bind rigid_transform_residual_jacobian rtj_checker u_rtj_checker (.*);

[tb/rigid_transform_residual_jacobian_checker.sv]
module rigid_transform_residual_jacobian_checker
  import rtj_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [223:0] out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [18:0]  cfg_data,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint sq;
    longint d [6];
    bit     last;
  } residual_t;

  localparam longint PI_C      = 64'sd3373259426;
  localparam longint HALF_PI_C = 64'sd1686629713;
  localparam longint TWO_PI_C  = 64'sd6746518852;
  localparam longint GAIN_C    = 64'sd652032875;
  localparam int     STEPS     = 16;

  longint pose [6];
  longint sin_cos [6];
  bit     sin_cos_ok;
  residual_t expected_q [$];

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return round_q(a * b, FRAC_BITS);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic cordic(input longint ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy, one;
    bit flip;
    z = ang * (64'sd1 <<< (30 - FRAC_BITS));
    x = GAIN_C;
    y = 0;
    one = 64'sd1 <<< FRAC_BITS;
    flip = 0;
    z = z % TWO_PI_C;
    if (z > PI_C) z -= TWO_PI_C;
    else if (z < -PI_C) z += TWO_PI_C;
    if (z > HALF_PI_C) begin
      z -= PI_C;
      flip = 1;
    end else if (z < -HALF_PI_C) begin
      z += PI_C;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
      end
    end
    x = round_q(x, 30 - FRAC_BITS);
    y = round_q(y, 30 - FRAC_BITS);
    if (flip) begin
      x = -x; y = -y;
    end
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    sn = y;
    cs = x;
  endtask

  task automatic predict_residual(input logic [119:0] d, input bit last);
    longint rx, ry, rz, sx, sy, sz, sr, cr, sp, cp, sw, cw;
    longint a, b, c, dd, r01, r02, r11, r12, r21, r22;
    longint q0, q1, q2, e0, e1, e2, g0, g1, g2, acc, w, u;
    residual_t r;
    if (!sin_cos_ok) begin
      for (int k = 0; k < 3; k++) cordic(pose[k], sin_cos[2*k], sin_cos[2*k+1]);
      sin_cos_ok = 1;
    end
    sr = sin_cos[0]; cr = sin_cos[1]; sp = sin_cos[2];
    cp = sin_cos[3]; sw = sin_cos[4]; cw = sin_cos[5];
    rx = longint'($signed(d[19:0]));   ry = longint'($signed(d[39:20]));
    rz = longint'($signed(d[59:40]));  sx = longint'($signed(d[79:60]));
    sy = longint'($signed(d[99:80]));  sz = longint'($signed(d[119:100]));
    a = fmul(sw, cr); b = fmul(sr, cw); c = fmul(sr, sw); dd = fmul(cr, cw);
    r01 = fmul(b, sp) - a;
    r02 = fmul(dd, sp) + c;
    r11 = fmul(c, sp) + dd;
    r12 = fmul(a, sp) - b;
    r21 = fmul(sr, cp);
    r22 = fmul(cr, cp);
    q0 = fmul(fmul(cw, cp), sx) + fmul(r01, sy) + fmul(r02, sz);
    q1 = fmul(fmul(sw, cp), sx) + fmul(r11, sy) + fmul(r12, sz);
    q2 = -fmul(sp, sx) + fmul(r21, sy) + fmul(r22, sz);
    e0 = q0 + pose[3] - rx;
    e1 = q1 + pose[4] - ry;
    e2 = q2 + pose[5] - rz;
    r.sq = round_q(e0 * e0 + e1 * e1 + e2 * e2, FRAC_BITS);
    if (r.sq > 64'sd4294967295) r.sq = 64'sd4294967295;
    g0 = fmul(r02, sy) - fmul(r01, sz);
    g1 = fmul(r12, sy) - fmul(r11, sz);
    g2 = fmul(r22, sy) - fmul(r21, sz);
    acc = e0 * g0 + e1 * g1 + e2 * g2;
    r.d[0] = clamp32(round_q(2 * acc, FRAC_BITS));
    w = fmul(sr, sy) + fmul(cr, sz);
    u = fmul(cp, w) - fmul(sp, sx);
    g0 = fmul(cw, u);
    g1 = fmul(sw, u);
    g2 = -fmul(cp, sx) - fmul(sp, w);
    acc = e0 * g0 + e1 * g1 + e2 * g2;
    r.d[1] = clamp32(round_q(2 * acc, FRAC_BITS));
    acc = e1 * q0 - e0 * q1;
    r.d[2] = clamp32(round_q(2 * acc, FRAC_BITS));
    r.d[3] = clamp32(2 * e0);
    r.d[4] = clamp32(2 * e1);
    r.d[5] = clamp32(2 * e2);
    r.last = last;
    expected_q.push_back(r);
  endtask

  task automatic compare_residual(input logic [223:0] d, input bit last);
    residual_t r;
    logic [31:0] want;
    string names [7];
    names = '{"sq_error", "d_roll", "d_pitch", "d_yaw",
              "d_shift_x", "d_shift_y", "d_shift_z"};
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction");
      fail_count++;
      return;
    end
    r = expected_q.pop_front();
    for (int f = 0; f < 7; f++) begin
      want = (f == 0) ? r.sq[31:0] : r.d[f-1][31:0];
      if (d[32*f +: 32] !== want) begin
        $error("%s expected %h actual %h", names[f], want, d[32*f +: 32]);
        fail_count++;
      end
    end
    if (last !== r.last) begin
      $error("last_result expected %0d actual %0d", r.last, last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pose = '{0, 0, 0, 0, 32768, 65536};
      sin_cos_ok = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < CFG_COUNT) begin
        if (cfg_index == CFG_SHIFT_Y) pose[cfg_index] = longint'({1'b0, cfg_data[17:0]});
        else pose[cfg_index] = longint'($signed(cfg_data));
        sin_cos_ok = 0;
      end
      if (out_tvalid && out_tready) compare_residual(out_tdata, out_tlast);
      if (in_tvalid && in_tready) predict_residual(in_tdata, in_tlast);
    end
    pending_count = expected_q.size();
  end

  always @(posedge clk) begin
    if (!rst_n) result_count <= 0;
    else if (out_tvalid && out_tready) result_count <= result_count + 1;
  end
endmodule

[tb/rigid_transform_residual_jacobian_tb.sv]
module rigid_transform_residual_jacobian_tb;
  import rtj_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [223:0] out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [18:0]  cfg_data;
  int           fail_count;
  int           pending_count;
  int           result_count;
  int           pairs_sent;
  int           idle_cycles;
  bit           stim_done;

  rigid_transform_residual_jacobian dut (.*);

  rigid_transform_residual_jacobian_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // output back-pressure, drawn per transaction
  initial begin
    int gap;
    out_tready = 0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        out_tready <= 0;
        @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("rigid_transform_residual_jacobian test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // valid stays high after a transaction so bursts run back to back;
  // a gap or a drain drops it
  task automatic send_pair(input logic [119:0] d, input bit last, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= d;
    in_tlast  <= last;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    pairs_sent++;
  endtask

  function automatic logic [19:0] rand_coord(input int mode);
    case (mode)
      0: return 20'($signed($urandom_range(0, 262144)) - 131072);
      1: return 20'h80000;
      2: return 20'h7FFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] rand_angle;
    case ($urandom_range(0, 4))
      0: return 19'(205887);
      1: return 19'(-205887);
      2: return 19'h40000;
      3: return 19'h3FFFF;
      default: return 19'($signed($urandom_range(0, 411774)) - 205887);
    endcase
  endfunction

  initial begin
    logic [119:0] d;
    int mode;
    bit burst;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tlast  = 0;
    cfg_valid = 0;
    cfg_index = CFG_ROLL;
    cfg_data  = '0;
    pairs_sent = 0;
    stim_done = 0;
    rst_n = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // reset pose first, with corner points
    send_pair('0, 0, 0);
    send_pair({6{20'h7FFFF}}, 1, 0);
    send_pair({6{20'h80000}}, 0, 0);
    send_pair({{3{20'h80000}}, {3{20'h7FFFF}}}, 1, 0);
    send_pair({{3{20'h7FFFF}}, {3{20'h80000}}}, 0, 0);
    send_pair({{3{20'h00000}}, 20'h10000, 20'h0, 20'h0}, 0, 0);
    drain();

    // extreme pose, angles near and beyond pi, and out-of-range indices
    write_reg(CFG_ROLL, 19'(205887));
    write_reg(CFG_PITCH, 19'(-205887));
    write_reg(CFG_YAW, 19'h40000);
    write_reg(CFG_SHIFT_X, 19'(-131072));
    write_reg(CFG_SHIFT_Y, 19'h7FFFF);
    write_reg(CFG_SHIFT_Z, 19'(131072));
    write_reg(CFG_COUNT, 19'h5A5A5);
    write_reg(3'd7, 19'h12345);
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 6; k++) d[20*k +: 20] = rand_coord(i % 4);
      send_pair(d, i[0], 0);
    end
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_ROLL, rand_angle());
      write_reg(CFG_PITCH, rand_angle());
      write_reg(CFG_YAW, rand_angle());
      write_reg(CFG_SHIFT_X, phase == 0 ? 19'(131072) : 19'($urandom));
      write_reg(CFG_SHIFT_Y, phase == 1 ? 19'd0 : 19'($urandom));
      write_reg(CFG_SHIFT_Z, phase == 1 ? 19'(-131072) : 19'($urandom));
      burst = (phase % 3 == 2);
      for (int i = 0; i < 48; i++) begin
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 6; k++)
          d[20*k +: 20] = rand_coord(mode < 6 ? 0 : (mode < 7 ? $urandom_range(1, 2) : 3));
        send_pair(d, $urandom_range(0, 7) == 0, burst);
      end
      drain();
    end
    stim_done = 1;

    drain();
    $display("covered %0d pairs, %0d results, reset pose and 9 register settings",
             pairs_sent, result_count);
    $display("including angle extremes, coordinate extremes and full back-to-back bursts");
    if (fail_count == 0)
      $display("rigid_transform_residual_jacobian test passed");
    else
      $display("rigid_transform_residual_jacobian test failed");
    $finish;
  end
endmodule

[rigid_transform_residual_jacobian.f]
rtl/core/rtj_pkg.sv
rtl/core/rtj_cordic.sv
rtl/core/rtj_rotate.sv
rtl/core/rtj_residual.sv
rtl/core/rigid_transform_residual_jacobian.sv
rtl/core/rtj_checker.sv
tb/rigid_transform_residual_jacobian_checker.sv
tb/rigid_transform_residual_jacobian_tb.sv
